FILE: hw/rtl/shiw_pkg.sv
// ----------------------------------------------------------------------------
// Station hit inverse weights: shared definitions
// Field widths, command codes, register addresses and control bundles.
// ----------------------------------------------------------------------------
package shiw_pkg;

  localparam int STATION_BITS   = 7;
  localparam int INDEX_BITS     = 6;
  localparam int WEIGHT_BITS    = 16;
  localparam int CFG_COUNT_BITS = 7;
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 24;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [APB_ADDR_BITS-1:0]  REG_STATION_COUNT   = 3'd0;
  localparam logic [CFG_COUNT_BITS-1:0] STATION_COUNT_RESET = 7'd64;

  // Control bundle from the sequencer to the count memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } mem_ctl_t;

endpackage

FILE: hw/rtl/shiw_count_mem.sv
// ----------------------------------------------------------------------------
// Station hit inverse weights: count memory
// One write and one registered read port, with a valid bit per entry so that
// the whole store reads as zero after reset or a clear.
// ----------------------------------------------------------------------------
module shiw_count_mem #(
  parameter int DEPTH      = 64,
  parameter int ADDR_BITS  = 6,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  shiw_pkg::mem_ctl_t    ctl,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] rd_data
);
  import shiw_pkg::*;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      valid;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

FILE: hw/rtl/shiw_divider.sv
// ----------------------------------------------------------------------------
// Station hit inverse weights: serial divider
// Restoring division that yields one quotient bit per cycle, computing
// floor(dividend * 2^(WEIGHT_BITS-1) / divisor) for dividend <= divisor.
// ----------------------------------------------------------------------------
module shiw_divider #(
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [COUNT_BITS-1:0]            dividend,
  input  logic [COUNT_BITS-1:0]            divisor,
  output logic                             done,
  output logic [shiw_pkg::WEIGHT_BITS-1:0] quotient
);
  import shiw_pkg::*;

  localparam int STEP_BITS = $clog2(WEIGHT_BITS + 1);
  localparam logic [STEP_BITS-1:0] STEPS = STEP_BITS'(WEIGHT_BITS);

  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvsr;
  logic [STEP_BITS-1:0]  steps_left;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // The first step produces the integer bit, so the remainder is not doubled.
  assign trial = (steps_left == STEPS) ? rem : {rem[COUNT_BITS-1:0], 1'b0};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dvsr     <= divisor;
      quotient <= '0;
    end else if (steps_left != '0) begin
      rem      <= fits ? trial - {1'b0, dvsr} : trial;
      quotient <= {quotient[WEIGHT_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      done       <= 1'b0;
    end else if (start) begin
      steps_left <= STEPS;
      done       <= 1'b0;
    end else begin
      done <= (steps_left == STEP_BITS'(1));
      if (steps_left != '0) begin
        steps_left <= steps_left - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/station_hit_inverse_weights_core.sv
// ----------------------------------------------------------------------------
// Station hit inverse weights
// Counts station hits from pair beats and, on a finish beat, emits one
// normalized inverse-count weight per configured station, up to MAX_STATIONS.
// ----------------------------------------------------------------------------
// A pair beat (tuser low) is handled in S_IDLE, S_WR_A, S_RD_B and S_WR_B:
// each of its two stations is read, incremented and written back through the
// count memory. A pair with a flagged or out-of-range station is dropped in its
// accepting cycle. A finish beat (tuser high) is accepted, then a scan in S_MIN
// reads each station once to find the least nonzero count, then each station
// gets a load (S_LOAD), a 16-step serial divider producing one weight bit per
// cycle followed by its done flag (S_DIV), and the output load (S_EMIT), which
// waits while the previous result beat is not yet taken. A finish with no
// station to emit is completed in its accepting cycle.
// The finish clears all counters with a single clear. A new beat is accepted as soon
// as the previous one is done, even while the last result beat still waits.
module station_hit_inverse_weights_core #(
  parameter int MAX_STATIONS = 64,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [shiw_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [shiw_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [shiw_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [shiw_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // station_a, station_b, pad
  input  logic                                 s_axis_tuser,  // cmd
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [shiw_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // station_index, weight, pad
  output logic                                 m_axis_tlast
);
  import shiw_pkg::*;

  localparam int ADDR_BITS = $clog2(MAX_STATIONS);
  localparam logic [STATION_BITS:0]     MAX_ST_W = (STATION_BITS + 1)'(MAX_STATIONS);
  localparam logic [CFG_COUNT_BITS-1:0] MAX_CFG  = CFG_COUNT_BITS'(MAX_STATIONS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_WR_A = 8'b0000_0010,
    S_RD_B = 8'b0000_0100,
    S_WR_B = 8'b0000_1000,
    S_MIN  = 8'b0001_0000,
    S_LOAD = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_COUNT_BITS-1:0] station_count;
  logic [ADDR_BITS-1:0]      sta, stb;
  logic [ADDR_BITS-1:0]      ptr;
  logic [ADDR_BITS-1:0]      last_ptr;
  logic [COUNT_BITS-1:0]     least;
  logic                      count_zero;

  logic [STATION_BITS-1:0]   in_sa, in_sb;
  logic                      sa_ok, sb_ok;
  logic                      in_fire, out_free, at_last;
  logic [CFG_COUNT_BITS-1:0] n_emit;

  mem_ctl_t                  mctl;
  logic [ADDR_BITS-1:0]      rd_addr;
  logic [COUNT_BITS-1:0]     rd_data;
  logic [COUNT_BITS-1:0]     cnt_inc;

  logic                      div_done;
  logic [WEIGHT_BITS-1:0]    quotient;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == REG_STATION_COUNT) ? APB_DATA_BITS'(station_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_count <= STATION_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_STATION_COUNT) begin
      station_count <= pwdata[CFG_COUNT_BITS-1:0];
    end
  end

  // ---------------- input decode ----------------
  assign in_sa   = s_axis_tdata[STATION_BITS-1:0];
  assign in_sb   = s_axis_tdata[2*STATION_BITS-1:STATION_BITS];
  assign sa_ok   = !in_sa[STATION_BITS-1] && ({1'b0, in_sa} < MAX_ST_W);
  assign sb_ok   = !in_sb[STATION_BITS-1] && ({1'b0, in_sb} < MAX_ST_W);
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign n_emit  = (station_count < MAX_CFG) ? station_count : MAX_CFG;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign at_last  = (ptr == last_ptr);
  assign cnt_inc  = (&rd_data) ? rd_data : rd_data + 1'b1;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next   = state;
    mctl         = '0;
    rd_addr      = ptr;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == CMD_ADD) begin
            if (sa_ok && sb_ok) begin
              mctl.rd_en = 1'b1;
              rd_addr    = in_sa[ADDR_BITS-1:0];
              state_next = S_WR_A;
            end
          end else if (n_emit == '0) begin
            mctl.clr_all = 1'b1;
          end else begin
            mctl.rd_en = 1'b1;
            rd_addr    = '0;
            state_next = S_MIN;
          end
        end
      end
      S_WR_A: begin
        mctl.wr_en = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        mctl.rd_en = 1'b1;
        rd_addr    = stb;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        mctl.wr_en = 1'b1;
        state_next = S_IDLE;
      end
      S_MIN: begin
        mctl.rd_en = 1'b1;
        if (at_last) begin
          rd_addr    = '0;
          state_next = S_LOAD;
        end else begin
          rd_addr = ptr + 1'b1;
        end
      end
      S_LOAD: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (at_last) begin
            mctl.clr_all = 1'b1;
            state_next   = S_IDLE;
          end else begin
            mctl.rd_en = 1'b1;
            rd_addr    = ptr + 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sta      <= in_sa[ADDR_BITS-1:0];
        stb      <= in_sb[ADDR_BITS-1:0];
        ptr      <= '0;
        least    <= '0;
        last_ptr <= ADDR_BITS'(n_emit - 1'b1);
      end
      S_MIN: begin
        if (rd_data != '0 && (least == '0 || rd_data < least)) begin
          least <= rd_data;
        end
        ptr <= at_last ? '0 : ptr + 1'b1;
      end
      S_LOAD: begin
        count_zero <= (rd_data == '0);
      end
      S_EMIT: begin
        if (out_free && !at_last) begin
          ptr <= ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- count memory ----------------
  shiw_count_mem #(
    .DEPTH      (MAX_STATIONS),
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .rd_addr (rd_addr),
    .wr_addr ((state == S_WR_A) ? sta : stb),
    .wr_data (cnt_inc),
    .rd_data (rd_data)
  );

  // ---------------- serial divider ----------------
  shiw_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (least),
    .divisor  (rd_data),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_axis_tdata <= OUT_TDATA_BITS'({(count_zero ? WEIGHT_BITS'(0) : quotient),
                                       INDEX_BITS'(ptr)});
      m_axis_tlast <= at_last;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Station hit inverse weights testbench
// Drives station pair beats and finish beats into the core through its input
// stream, sets the station count over APB, and compares every weight beat
// with a local model of the hit counters and the inverse-count weights.
// ----------------------------------------------------------------------------
module tb;
  import shiw_pkg::*;

  localparam int N_STATIONS     = 64;
  localparam int N_COUNT_BITS   = 16;
  localparam int RANDOM_ITEMS   = 410;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam bit [6:0] FLAGGED  = 7'h7F;

  typedef enum bit [1:0] {
    ROW_ADD,
    ROW_FINISH,
    ROW_CFG
  } row_kind_e;

  // For ROW_CFG the station count to write travels in sta.
  typedef struct packed {
    row_kind_e  kind;
    bit [6:0]   sta;
    bit [6:0]   stb;
    bit         typed;
    bit [15:0]  typed_w;
  } stim_row_t;

  typedef struct packed {
    bit [5:0]  idx;
    bit [15:0] weight;
    bit        last;
  } weight_beat_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{ROW_FINISH, 7'd0,   7'd0,   1'b1, 16'd0},  // nothing hit since reset
    '{ROW_ADD,    FLAGGED, 7'd3,  1'b0, 16'd0},
    '{ROW_ADD,    7'd3,   FLAGGED, 1'b0, 16'd0},
    '{ROW_ADD,    7'h40,  7'h40,  1'b0, 16'd0},
    '{ROW_ADD,    FLAGGED, FLAGGED, 1'b0, 16'd0},
    '{ROW_FINISH, 7'd0,   7'd0,   1'b1, 16'd0},  // flagged pairs left no hits
    '{ROW_ADD,    7'd0,   7'd63,  1'b0, 16'd0},
    '{ROW_ADD,    7'd63,  7'd0,   1'b0, 16'd0},
    '{ROW_ADD,    7'd7,   7'd7,   1'b0, 16'd0},
    '{ROW_ADD,    7'd7,   7'd8,   1'b0, 16'd0},
    '{ROW_FINISH, 7'h55,  7'h2A,  1'b0, 16'd0},
    '{ROW_CFG,    7'd2,   7'd0,   1'b0, 16'd0},
    '{ROW_ADD,    7'd0,   7'd1,   1'b0, 16'd0},
    '{ROW_ADD,    7'd0,   7'd0,   1'b0, 16'd0},
    '{ROW_ADD,    7'd5,   7'd6,   1'b0, 16'd0},
    '{ROW_FINISH, 7'h2A,  7'h55,  1'b0, 16'd0},
    '{ROW_CFG,    7'd0,   7'd0,   1'b0, 16'd0},
    '{ROW_ADD,    7'd4,   7'd9,   1'b0, 16'd0},
    '{ROW_FINISH, 7'd0,   7'd0,   1'b0, 16'd0},
    '{ROW_CFG,    7'd64,  7'd0,   1'b0, 16'd0},
    '{ROW_FINISH, 7'd0,   7'd0,   1'b1, 16'd0},  // empty finish still cleared
    '{ROW_CFG,    7'd100, 7'd0,   1'b0, 16'd0},
    '{ROW_ADD,    7'd62,  7'd63,  1'b0, 16'd0},
    '{ROW_ADD,    7'd63,  7'd63,  1'b0, 16'd0},
    '{ROW_FINISH, 7'd0,   7'd0,   1'b0, 16'd0}
  };

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_BITS-1:0]  paddr;
  logic [APB_DATA_BITS-1:0]  pwdata;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;   // station_a, station_b, pad
  logic                      s_axis_tuser;   // cmd
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // station_index, weight, pad
  logic                      m_axis_tlast;

  bit [N_COUNT_BITS-1:0] hit_counts [N_STATIONS];
  bit [6:0]              station_count_cfg;
  weight_beat_t          pending_weights [$];
  int                    errors;
  int                    idle_cycles;
  int                    sink_wait;
  bit                    src_calm;
  bit                    sink_calm;

  station_hit_inverse_weights_core #(
    .MAX_STATIONS(N_STATIONS),
    .COUNT_BITS  (N_COUNT_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic bit [N_COUNT_BITS-1:0] sat_inc(input bit [N_COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Mostly stations inside the span, now and then a flag or any 7-bit pattern.
  function automatic bit [6:0] pick_station(input int span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return FLAGGED;
    if (r == 1) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, span));
  endfunction

  task automatic predict_weights(input logic cmd, input bit [6:0] sta, input bit [6:0] stb,
                                 input bit typed, input bit [15:0] typed_w);
    int           n;
    bit [15:0]    least;
    bit [31:0]    quot;
    weight_beat_t beat;
    if (cmd == CMD_ADD) begin
      // A negative station (sign bit set) drops the whole pair.
      if (!sta[6] && !stb[6]) begin
        hit_counts[sta[5:0]] = sat_inc(hit_counts[sta[5:0]]);
        hit_counts[stb[5:0]] = sat_inc(hit_counts[stb[5:0]]);
      end
    end else begin
      n = (station_count_cfg > N_STATIONS) ? N_STATIONS : int'(station_count_cfg);
      least = '0;
      for (int i = 0; i < n; i++) begin
        if (hit_counts[i] != 0 && (least == 0 || hit_counts[i] < least)) least = hit_counts[i];
      end
      for (int i = 0; i < n; i++) begin
        quot = (hit_counts[i] == 0) ? 32'd0 : (32'(least) * 32'd32768) / 32'(hit_counts[i]);
        beat.idx    = 6'(i);
        beat.weight = typed ? typed_w : quot[15:0];
        beat.last   = (i == n - 1);
        pending_weights.push_back(beat);
      end
      foreach (hit_counts[i]) hit_counts[i] = '0;
    end
  endtask

  task automatic send_beat(input logic cmd, input bit [6:0] sta, input bit [6:0] stb,
                           input bit typed, input bit [15:0] typed_w);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, stb, sta};
    do @(posedge clk); while (!s_axis_tready);
    predict_weights(cmd, sta, stb, typed, typed_w);
  endtask

  // Wait out every pending weight, then give the core time to finish clearing.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write then read back, as two back-to-back transfers.
  task automatic write_station_count(input bit [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STATION_COUNT;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    station_count_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      report_mismatch($sformatf("station_count read %0d, wrote %0d", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : sink_ctl
    int gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      gap = draw_gap(sink_calm);
      sink_wait     <= gap;
      m_axis_tready <= (gap == 0);
    end else if (!m_axis_tready) begin
      if (sink_wait <= 1) m_axis_tready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  always @(posedge clk) begin : check_weights
    weight_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch($sformatf("weight beat %h with nothing expected", m_axis_tdata));
      end else begin
        want = pending_weights.pop_front();
        if (m_axis_tdata[5:0] !== want.idx)
          report_mismatch($sformatf("station_index %0d, expected %0d",
                                    m_axis_tdata[5:0], want.idx));
        if (m_axis_tdata[21:6] !== want.weight)
          report_mismatch($sformatf("weight %0d for station %0d, expected %0d",
                                    m_axis_tdata[21:6], want.idx, want.weight));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %b for station %0d, expected %b",
                                    m_axis_tlast, want.idx, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int        counted;
    int        pick;
    int        span;
    int        len;
    int        emitted;
    bit [6:0]  cfg;
    bit [6:0]  sta;
    bit [6:0]  stb;
    stim_row_t row;
    errors            = 0;
    src_calm          = 1'b0;
    sink_calm         = 1'b0;
    station_count_cfg = STATION_COUNT_RESET;
    foreach (hit_counts[i]) hit_counts[i] = '0;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_ADD;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      case (row.kind)
        ROW_CFG: begin
          settle_block();
          write_station_count(row.sta);
        end
        ROW_ADD: send_beat(CMD_ADD, row.sta, row.stb, 1'b0, 16'd0);
        default: send_beat(CMD_FINISH, row.sta, row.stb, row.typed, row.typed_w);
      endcase
    end

    // Random phases: each sets a station count, sends pairs, and ends in a finish.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: cfg = 7'd2;
        1: cfg = 7'd64;
        2: cfg = 7'd0;
        3: cfg = 7'($urandom_range(65, 127));
        default: cfg = 7'($urandom_range(2, 64));
      endcase
      settle_block();
      write_station_count(cfg);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      emitted = (cfg > N_STATIONS) ? N_STATIONS : int'(cfg);
      span = (emitted == 0 || $urandom_range(0, 3) == 0) ? 63 : emitted - 1;
      len = $urandom_range(8, 40);
      for (int k = 0; k < len; k++) begin
        if (k == len - 1 || $urandom_range(0, 11) == 0) begin
          send_beat(CMD_FINISH, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    1'b0, 16'd0);
          if ($urandom_range(0, 3) == 0) settle_block();
        end else begin
          sta = pick_station(span);
          stb = pick_station(span);
          send_beat(CMD_ADD, sta, stb, 1'b0, 16'd0);
        end
        counted++;
      end
    end

    settle_block();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
